FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files of the console writer.
// Both forms sample on the rising clock and are quiet while reset is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AM_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared widths, codes and the microcode program of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default geometry of the console.
    localparam int COLUMNS_DEF      = 80;
    localparam int SCREEN_CELLS_DEF = 2000;
    localparam int BUFFER_CELLS_DEF = 8000;

    // Fixed field widths.
    localparam int CELL_W     = 16;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int IDX_W      = 13;
    localparam int OUT_W      = 16;
    localparam int ACTION_W   = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // Control characters.
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

    // Request kinds.
    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT       = 2'd0,
        ACT_VIEW_UP   = 2'd1,
        ACT_VIEW_DOWN = 2'd2,
        ACT_READ      = 2'd3
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_TEXT_COLOR  = 2'd0,
        CFG_BLANK_COLOR = 2'd1,
        CFG_FOREGROUND  = 2'd2,
        CFG_BASE_OFFSET = 2'd3
    } cfg_index_t;

    // Datapath operations selected by a control word.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_PUT,
        OP_VIEW_UP,
        OP_VIEW_DOWN,
        OP_READ,
        OP_SCROLL_BEGIN,
        OP_COPY_RD,
        OP_COPY_WR,
        OP_FILL,
        OP_FOLLOW,
        OP_EMIT
    } uop_t;

    // Branch conditions.
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_REQ,
        C_PTR_NOT_LAST,
        C_PTR_NOT_KEEP_LAST,
        C_CUR_AT_END,
        C_FG_BEHIND,
        C_OUT_BUSY
    } ucond_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Program addresses.
    localparam step_t S_CLEAR      = 4'd0;
    localparam step_t S_IDLE       = 4'd1;
    localparam step_t S_PUT        = 4'd2;
    localparam step_t S_UP         = 4'd3;
    localparam step_t S_DOWN       = 4'd4;
    localparam step_t S_READ       = 4'd5;
    localparam step_t S_WRAP_CHK   = 4'd6;
    localparam step_t S_SCROLL     = 4'd7;
    localparam step_t S_COPY_RD    = 4'd8;
    localparam step_t S_COPY_WR    = 4'd9;
    localparam step_t S_FILL       = 4'd10;
    localparam step_t S_FOLLOW     = 4'd11;
    localparam step_t S_EMIT       = 4'd12;

    // One control word: operation, branch condition, and both successors.
    // With dispatch set, a taken branch adds the request kind to the target.
    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        logic   dispatch;
        step_t  t_true;
        step_t  t_false;
    } uword_t;

    // The program ROM. The four request entries start at S_PUT, in the
    // order of the request kind codes.
    function automatic uword_t tcw_ucode(input step_t step);
        uword_t w;
        begin
            case (step)
                S_CLEAR:    w = '{OP_CLEAR,        C_PTR_NOT_LAST,      1'b0, S_CLEAR,   S_IDLE};
                S_IDLE:     w = '{OP_ACCEPT,       C_REQ,               1'b1, S_PUT,     S_IDLE};
                S_PUT:      w = '{OP_PUT,          C_ALWAYS,            1'b0, S_WRAP_CHK, S_WRAP_CHK};
                S_UP:       w = '{OP_VIEW_UP,      C_ALWAYS,            1'b0, S_EMIT,    S_EMIT};
                S_DOWN:     w = '{OP_VIEW_DOWN,    C_ALWAYS,            1'b0, S_EMIT,    S_EMIT};
                S_READ:     w = '{OP_READ,         C_ALWAYS,            1'b0, S_EMIT,    S_EMIT};
                S_WRAP_CHK: w = '{OP_NONE,         C_CUR_AT_END,        1'b0, S_SCROLL,  S_FOLLOW};
                S_SCROLL:   w = '{OP_SCROLL_BEGIN, C_ALWAYS,            1'b0, S_COPY_RD, S_COPY_RD};
                S_COPY_RD:  w = '{OP_COPY_RD,      C_ALWAYS,            1'b0, S_COPY_WR, S_COPY_WR};
                S_COPY_WR:  w = '{OP_COPY_WR,      C_PTR_NOT_KEEP_LAST, 1'b0, S_COPY_RD, S_FILL};
                S_FILL:     w = '{OP_FILL,         C_PTR_NOT_LAST,      1'b0, S_FILL,    S_FOLLOW};
                S_FOLLOW:   w = '{OP_FOLLOW,       C_FG_BEHIND,         1'b0, S_FOLLOW,  S_EMIT};
                S_EMIT:     w = '{OP_EMIT,         C_OUT_BUSY,          1'b0, S_EMIT,    S_IDLE};
                default:    w = '{OP_NONE,         C_ALWAYS,            1'b0, S_IDLE,    S_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage

FILE: hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text console engine with a scrolling cell buffer, run by a small microcode.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel (action, char_code, cell_index) and each
// yields exactly one result on the m_ channel. Configuration registers are
// written through cfg_valid/cfg_addr/cfg_data; cfg_ready is always high.
// After reset a clearing pass writes zero to every cell, one cell per cycle,
// and s_ready stays low until the pass ends; configuration is taken then.
// A request is taken in the idle step and then runs on the step counter:
//   view scroll or read cell: the action step, then the emit step loads
//   the result; put character: put, wrap check, follow, emit, where the
//   follow step repeats while the view catches up, a row at a time, in
//   foreground; a put that scrolls the buffer adds scroll, copy read and
//   copy write in turn per kept cell through the single read port, and fill.
// A new request can be accepted in the cycle after the result is loaded.
// The result sits in an output register; a stalled receiver holds it there
// while the next request is accepted and worked on, and that request waits
// in its final step until the register is free.
// ----------------------------------------------------------------------------
module text_console_writer #(
    parameter int COLUMNS      = tcw_pkg::COLUMNS_DEF,
    parameter int SCREEN_CELLS = tcw_pkg::SCREEN_CELLS_DEF,
    parameter int BUFFER_CELLS = tcw_pkg::BUFFER_CELLS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tcw_pkg::ACTION_W-1:0]    s_action,
    input  logic [tcw_pkg::CHAR_W-1:0]      s_char_code,
    input  logic [tcw_pkg::IDX_W-1:0]       s_cell_index,
    // Result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tcw_pkg::OUT_W-1:0]       m_cursor_address,
    output logic [tcw_pkg::OUT_W-1:0]       m_display_start,
    output logic                            m_registers_updated,
    output logic                            m_buffer_scrolled,
    output logic [tcw_pkg::CELL_W-1:0]      m_cell_value,
    // Configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcw_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import tcw_pkg::*;

    localparam int ADDR_W = $clog2(BUFFER_CELLS);
    localparam int POS_W  = $clog2(BUFFER_CELLS + 2 * COLUMNS + SCREEN_CELLS + 1);
    localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int KEEP   = BUFFER_CELLS - COLUMNS;

    // Configuration registers.
    logic [COLOR_W-1:0] text_color_reg;
    logic [COLOR_W-1:0] blank_color_reg;
    logic               foreground_reg;
    logic [OUT_W-1:0]   base_offset_reg;

    // Sequencer and datapath registers.
    step_t              step_reg, step_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [POS_W-1:0]   cursor_reg, cursor_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [POS_W-1:0]   view_reg, view_next;
    logic               updated_reg, updated_next;
    logic               scrolled_reg, scrolled_next;
    logic               out_valid_reg, out_valid_next;

    // Request and result payload registers.
    action_t            action_reg, action_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [OUT_W-1:0]   out_cursor_reg, out_cursor_next;
    logic [OUT_W-1:0]   out_start_reg, out_start_next;
    logic               out_updated_reg, out_updated_next;
    logic               out_scrolled_reg, out_scrolled_next;
    logic [CELL_W-1:0]  out_cell_reg, out_cell_next;

    // Memory port signals.
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [CELL_W-1:0]  ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    logic [CELL_W-1:0]  ram_rdata;

    // Decode helpers.
    uword_t                    ctrl;
    logic                      cond_true;
    logic                      in_fire;
    logic                      out_busy;
    logic                      behind;
    logic                      idx_ok;
    logic [ADDR_W+IDX_W-1:0]   idx_wide;
    logic [ADDR_W-1:0]         ptr_plus_col;
    logic [POS_W-1:0]          cursor_dec;
    logic [POS_W-1:0]          bs_pos;
    logic [CELL_W-1:0]         blank_cell;

    assign ctrl      = tcw_ucode(step_reg);
    assign s_ready   = (ctrl.op == OP_ACCEPT);
    assign in_fire   = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign out_busy  = out_valid_reg && !m_ready;

    assign behind       = (cursor_reg >= view_reg + POS_W'(SCREEN_CELLS));
    assign idx_wide     = {{ADDR_W{1'b0}}, idx_reg};
    assign idx_ok       = (idx_wide < (ADDR_W + IDX_W)'(BUFFER_CELLS));
    assign ptr_plus_col = ADDR_W'({1'b0, ptr_reg} + (ADDR_W + 1)'(COLUMNS));
    assign cursor_dec   = cursor_reg - 1'b1;
    assign bs_pos       = (cursor_reg == '0) ? '0 : cursor_dec;
    assign blank_cell   = {blank_color_reg, {CHAR_W{1'b0}}};

    // Branch condition of the current control word.
    always_comb begin
        case (ctrl.cond)
            C_ALWAYS:            cond_true = 1'b1;
            C_REQ:               cond_true = s_valid;
            C_PTR_NOT_LAST:      cond_true = (ptr_reg != ADDR_W'(BUFFER_CELLS - 1));
            C_PTR_NOT_KEEP_LAST: cond_true = (ptr_reg != ADDR_W'(KEEP - 1));
            C_CUR_AT_END:        cond_true = (cursor_reg >= POS_W'(BUFFER_CELLS));
            C_FG_BEHIND:         cond_true = foreground_reg && behind;
            C_OUT_BUSY:          cond_true = out_busy;
            default:             cond_true = 1'b0;
        endcase
    end

    // Step counter: taken branch, dispatched branch, or fall-back target.
    always_comb begin
        if (cond_true && ctrl.dispatch) begin
            step_next = ctrl.t_true + STEP_W'(s_action);
        end else if (cond_true) begin
            step_next = ctrl.t_true;
        end else begin
            step_next = ctrl.t_false;
        end
    end

    // Datapath driven by the operation field.
    always_comb begin
        ptr_next          = ptr_reg;
        cursor_next       = cursor_reg;
        col_next          = col_reg;
        view_next         = view_reg;
        updated_next      = updated_reg;
        scrolled_next     = scrolled_reg;
        action_next       = action_reg;
        char_next         = char_reg;
        idx_next          = idx_reg;
        out_cursor_next   = out_cursor_reg;
        out_start_next    = out_start_reg;
        out_updated_next  = out_updated_reg;
        out_scrolled_next = out_scrolled_reg;
        out_cell_next     = out_cell_reg;
        out_valid_next    = out_valid_reg && !m_ready;
        ram_we            = 1'b0;
        ram_waddr         = ptr_reg;
        ram_wdata         = '0;
        ram_re            = 1'b0;
        ram_raddr         = ptr_reg;

        case (ctrl.op)
            OP_CLEAR: begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg + 1'b1;
            end
            OP_ACCEPT: begin
                if (in_fire) begin
                    action_next   = action_t'(s_action);
                    char_next     = s_char_code;
                    idx_next      = s_cell_index;
                    updated_next  = 1'b0;
                    scrolled_next = 1'b0;
                end
            end
            OP_PUT: begin
                if (char_reg == CH_NEWLINE) begin
                    cursor_next = cursor_reg - POS_W'(col_reg) + POS_W'(COLUMNS);
                    col_next    = '0;
                end else if (char_reg == CH_BACKSPACE) begin
                    // Backspace at the first cell holds there and blanks it.
                    ram_we    = 1'b1;
                    ram_waddr = bs_pos[ADDR_W-1:0];
                    ram_wdata = blank_cell;
                    if (cursor_reg != '0) begin
                        cursor_next = cursor_dec;
                        col_next    = (col_reg == '0) ? COL_W'(COLUMNS - 1) : col_reg - 1'b1;
                    end
                end else begin
                    ram_we      = 1'b1;
                    ram_waddr   = cursor_reg[ADDR_W-1:0];
                    ram_wdata   = {text_color_reg, char_reg};
                    cursor_next = cursor_reg + 1'b1;
                    col_next    = (col_reg == COL_W'(COLUMNS - 1)) ? '0 : col_reg + 1'b1;
                end
            end
            OP_VIEW_UP: begin
                if (view_reg != '0) begin
                    view_next    = (view_reg >= POS_W'(COLUMNS)) ?
                                   view_reg - POS_W'(COLUMNS) : '0;
                    updated_next = foreground_reg;
                end
            end
            OP_VIEW_DOWN: begin
                if (behind) begin
                    view_next    = view_reg + POS_W'(COLUMNS);
                    updated_next = foreground_reg;
                end
            end
            OP_READ: begin
                ram_re    = 1'b1;
                ram_raddr = idx_wide[ADDR_W-1:0];
            end
            OP_SCROLL_BEGIN: begin
                ptr_next      = '0;
                scrolled_next = 1'b1;
                cursor_next   = cursor_reg - POS_W'(COLUMNS);
            end
            OP_COPY_RD: begin
                ram_re    = 1'b1;
                ram_raddr = ptr_plus_col;
            end
            OP_COPY_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ptr_next  = ptr_reg + 1'b1;
            end
            OP_FILL: begin
                ram_we    = 1'b1;
                ram_wdata = blank_cell;
                ptr_next  = ptr_reg + 1'b1;
            end
            OP_FOLLOW: begin
                // In foreground the view walks down a row at a time.
                if (foreground_reg) begin
                    updated_next = 1'b1;
                end
                if (cond_true) begin
                    view_next = view_reg + POS_W'(COLUMNS);
                end
            end
            OP_EMIT: begin
                if (!out_busy) begin
                    out_valid_next    = 1'b1;
                    out_cursor_next   = base_offset_reg + OUT_W'(cursor_reg);
                    out_start_next    = base_offset_reg + OUT_W'(view_reg);
                    out_updated_next  = updated_reg;
                    out_scrolled_next = scrolled_reg;
                    out_cell_next     = (action_reg == ACT_READ && idx_ok) ? ram_rdata : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= S_CLEAR;
            ptr_reg       <= '0;
            cursor_reg    <= '0;
            col_reg       <= '0;
            view_reg      <= '0;
            updated_reg   <= 1'b0;
            scrolled_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            ptr_reg       <= ptr_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            view_reg      <= view_next;
            updated_reg   <= updated_next;
            scrolled_reg  <= scrolled_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        action_reg       <= action_next;
        char_reg         <= char_next;
        idx_reg          <= idx_next;
        out_cursor_reg   <= out_cursor_next;
        out_start_reg    <= out_start_next;
        out_updated_reg  <= out_updated_next;
        out_scrolled_reg <= out_scrolled_next;
        out_cell_reg     <= out_cell_next;
    end

    // Configuration register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg  <= COLOR_W'(7);
            blank_color_reg <= COLOR_W'(7);
            foreground_reg  <= 1'b0;
            base_offset_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_addr))
                CFG_TEXT_COLOR:  text_color_reg  <= cfg_data[COLOR_W-1:0];
                CFG_BLANK_COLOR: blank_color_reg <= cfg_data[COLOR_W-1:0];
                CFG_FOREGROUND:  foreground_reg  <= cfg_data[0];
                CFG_BASE_OFFSET: base_offset_reg <= cfg_data[OUT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Cell store.
    tcw_cell_ram #(
        .DEPTH (BUFFER_CELLS)
    ) u_cell_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Result channel.
    assign m_valid             = out_valid_reg;
    assign m_cursor_address    = out_cursor_reg;
    assign m_display_start     = out_start_reg;
    assign m_registers_updated = out_updated_reg;
    assign m_buffer_scrolled   = out_scrolled_reg;
    assign m_cell_value        = out_cell_reg;

endmodule

FILE: hw/rtl/tcw_cell_ram.sv
// ----------------------------------------------------------------------------
// tcw_cell_ram
// Simple dual-port cell store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_cell_ram #(
    parameter int DEPTH = tcw_pkg::BUFFER_CELLS_DEF
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [tcw_pkg::CELL_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [tcw_pkg::CELL_W-1:0]  rd_data
);
    import tcw_pkg::*;

    logic [CELL_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with registered data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [tcw_pkg::OUT_W-1:0]      m_cursor_address,
    input logic [tcw_pkg::OUT_W-1:0]      m_display_start,
    input logic                           m_registers_updated,
    input logic                           m_buffer_scrolled,
    input logic [tcw_pkg::CELL_W-1:0]     m_cell_value
);
    import tcw_pkg::*;

    // A stalled result keeps every field.
    `AM_ASSERT_NEXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_cursor_address) && $stable(m_display_start) && $stable(m_registers_updated) && $stable(m_buffer_scrolled) && $stable(m_cell_value))

    // One request at a time: the sequencer leaves its idle step on acceptance.
    `AM_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A nonzero cell value comes only from a read, which moves nothing.
    `AM_ASSERT_SAME(a_read_quiet, aclk, aresetn, m_valid && (m_cell_value != '0), !m_registers_updated && !m_buffer_scrolled)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
